// ----- design/ffra_pkg.sv -----
// Shared types and constants for the first-fit rectangle allocator.
package ffra_pkg;

  localparam int unsigned MAX_RECTS_DEF = 64;
  localparam int unsigned MAX_SIDE_DEF  = 4096;

  // Widths fixed by the port fields
  localparam int unsigned SIDE_W  = 13;
  localparam int unsigned CORN_W  = 12;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned USED_W  = 7;
  // Internal coordinate width: holds the sum of two sides
  localparam int unsigned CRD_W   = SIDE_W + 2;

  localparam logic [11:0] ATLAS_RESET = 12'd512;

  // Configuration register indexes
  localparam logic REG_ATLAS_WIDTH  = 1'b0;
  localparam logic REG_ATLAS_HEIGHT = 1'b1;

  typedef enum logic {
    ACT_PLACE  = 1'b0,
    ACT_REMOVE = 1'b1
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_PLACED   = 3'd0,
    ST_NO_ROOM  = 3'd1,
    ST_REMOVED  = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ROW,
    S_CAND,
    S_RD,
    S_CHK,
    S_FOUND,
    S_DEL_RD,
    S_DEL_CHK,
    S_SH_RD,
    S_SH_WR,
    S_DONE
  } fsm_t;

  // One table entry
  typedef struct packed {
    logic [CORN_W-1:0] left;
    logic [CORN_W-1:0] top;
    logic [SIDE_W-1:0] wide;
    logic [SIDE_W-1:0] tall;
  } entry_t;

endpackage

// ----- design/ffra_ifs.sv -----
// Request, response and configuration channel interfaces.
interface ffra_req_if;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [ffra_pkg::SIDE_W-1:0] rect_width;
  logic [ffra_pkg::SIDE_W-1:0] rect_height;
  logic [ffra_pkg::CORN_W-1:0] corner_x;
  logic [ffra_pkg::CORN_W-1:0] corner_y;
  modport source (output valid, action, rect_width, rect_height, corner_x, corner_y,
                  input ready);
  modport sink (input valid, action, rect_width, rect_height, corner_x, corner_y,
                output ready);
endinterface

interface ffra_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [ffra_pkg::STAT_W-1:0] status;
  logic [ffra_pkg::CORN_W-1:0] out_x;
  logic [ffra_pkg::CORN_W-1:0] out_y;
  logic [ffra_pkg::USED_W-1:0] entries_used;
  modport source (output valid, status, out_x, out_y, entries_used, input ready);
  modport sink (input valid, status, out_x, out_y, entries_used, output ready);
endinterface

interface ffra_cfg_if;
  logic                        valid;
  logic                        ready;
  logic                        reg_index;
  logic [ffra_pkg::SIDE_W-1:0] wr_data;
  modport source (output valid, reg_index, wr_data, input ready);
  modport sink (input valid, reg_index, wr_data, output ready);
endinterface

// ----- design/ffra_table.sv -----
// Rectangle table: single-port-write, registered-read memory.
module ffra_table #(
  parameter int unsigned MAX_RECTS = ffra_pkg::MAX_RECTS_DEF,
  localparam int unsigned IW = $clog2(MAX_RECTS)
) (
  input  logic                 clk,
  input  logic                 rd_en,
  input  logic [IW-1:0]        rd_addr,
  output ffra_pkg::entry_t     rd_data,
  input  logic                 wr_en,
  input  logic [IW-1:0]        wr_addr,
  input  ffra_pkg::entry_t     wr_data
);

  ffra_pkg::entry_t mem [MAX_RECTS];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered output
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- design/ffra_ctrl.sv -----
// Search and remove sequencer with result register.
module ffra_ctrl #(
  parameter int unsigned MAX_RECTS = ffra_pkg::MAX_RECTS_DEF,
  localparam int unsigned IW = $clog2(MAX_RECTS),
  localparam int unsigned CW = $clog2(MAX_RECTS + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [ffra_pkg::SIDE_W-1:0] aw,
  input  logic [ffra_pkg::SIDE_W-1:0] ah,
  ffra_req_if.sink                    req,
  ffra_rsp_if.source                  rsp,
  output logic                        rd_en,
  output logic [IW-1:0]               rd_addr,
  input  ffra_pkg::entry_t            rd_data,
  output logic                        wr_en,
  output logic [IW-1:0]               wr_addr,
  output ffra_pkg::entry_t            wr_data
);

  localparam int unsigned D = ffra_pkg::CRD_W;

  ffra_pkg::fsm_t state, state_next;

  logic [ffra_pkg::SIDE_W-1:0] w, h;
  logic [ffra_pkg::CORN_W-1:0] cx, cy;
  logic [D-1:0]                x, y, row_next;
  logic [IW-1:0]               idx;
  logic [CW-1:0]               count;
  ffra_pkg::status_t           st;
  logic [ffra_pkg::CORN_W-1:0] px, py;

  logic                        res_valid;
  ffra_pkg::status_t           res_status;
  logic [ffra_pkg::CORN_W-1:0] res_x, res_y;
  logic [ffra_pkg::USED_W-1:0] res_used;

  logic         in_fire, out_free;
  logic [CW-1:0] idx_p1, idx_p2;
  logic [D-1:0] e_left, e_top, e_right, e_bottom;
  logic         hit, match, full, row_fail, cand_fail;

  assign in_fire  = req.valid && req.ready;
  assign out_free = !res_valid || rsp.ready;
  assign idx_p1   = CW'(idx) + CW'(1);
  assign idx_p2   = CW'(idx) + CW'(2);
  assign full     = (count == CW'(MAX_RECTS));

  // candidate test against the entry just read
  assign e_left   = D'(rd_data.left);
  assign e_top    = D'(rd_data.top);
  assign e_right  = e_left + D'(rd_data.wide);
  assign e_bottom = e_top + D'(rd_data.tall);
  assign hit = (x < e_right) && (e_left < x + D'(w)) &&
               (y < e_bottom) && (e_top < y + D'(h));
  assign match     = (rd_data.left == cx) && (rd_data.top == cy);
  assign row_fail  = (y + D'(h)) > D'(ah);
  assign cand_fail = (x + D'(w)) > D'(aw);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ffra_pkg::S_IDLE: begin
        if (in_fire) begin
          if (req.action == ffra_pkg::ACT_REMOVE) begin
            state_next = (count == '0) ? ffra_pkg::S_DONE : ffra_pkg::S_DEL_RD;
          end else if (full || req.rect_width == '0 || req.rect_height == '0) begin
            state_next = ffra_pkg::S_DONE;
          end else begin
            state_next = ffra_pkg::S_ROW;
          end
        end
      end
      ffra_pkg::S_ROW:   state_next = row_fail ? ffra_pkg::S_DONE : ffra_pkg::S_CAND;
      ffra_pkg::S_CAND: begin
        if (cand_fail) begin
          state_next = ffra_pkg::S_ROW;
        end else if (count == '0) begin
          state_next = ffra_pkg::S_FOUND;
        end else begin
          state_next = ffra_pkg::S_RD;
        end
      end
      ffra_pkg::S_RD:    state_next = ffra_pkg::S_CHK;
      ffra_pkg::S_CHK: begin
        if (hit) begin
          state_next = ffra_pkg::S_CAND;
        end else if (idx_p1 == count) begin
          state_next = ffra_pkg::S_FOUND;
        end else begin
          state_next = ffra_pkg::S_RD;
        end
      end
      ffra_pkg::S_FOUND: state_next = ffra_pkg::S_DONE;
      ffra_pkg::S_DEL_RD: state_next = ffra_pkg::S_DEL_CHK;
      ffra_pkg::S_DEL_CHK: begin
        if (match) begin
          state_next = (idx_p1 == count) ? ffra_pkg::S_DONE : ffra_pkg::S_SH_RD;
        end else begin
          state_next = (idx_p1 == count) ? ffra_pkg::S_DONE : ffra_pkg::S_DEL_RD;
        end
      end
      ffra_pkg::S_SH_RD: state_next = ffra_pkg::S_SH_WR;
      ffra_pkg::S_SH_WR: state_next = (idx_p2 == count) ? ffra_pkg::S_DONE : ffra_pkg::S_SH_RD;
      ffra_pkg::S_DONE:  state_next = out_free ? ffra_pkg::S_IDLE : ffra_pkg::S_DONE;
      default:           state_next = ffra_pkg::S_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx;
    wr_en   = 1'b0;
    wr_addr = idx;
    wr_data = rd_data;
    unique case (state)
      ffra_pkg::S_RD, ffra_pkg::S_DEL_RD: rd_en = 1'b1;
      ffra_pkg::S_SH_RD: begin
        rd_en   = 1'b1;
        rd_addr = IW'(idx_p1);
      end
      ffra_pkg::S_SH_WR: wr_en = 1'b1;
      ffra_pkg::S_FOUND: begin
        wr_en   = 1'b1;
        wr_addr = IW'(count);
        wr_data = '{left: ffra_pkg::CORN_W'(x), top: ffra_pkg::CORN_W'(y), wide: w, tall: h};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ffra_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (state == ffra_pkg::S_FOUND) begin
      count <= count + CW'(1);
    end else if ((state == ffra_pkg::S_DEL_CHK && match && idx_p1 == count) ||
                 (state == ffra_pkg::S_SH_WR && idx_p2 == count)) begin
      count <= count - CW'(1);
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (state)
      ffra_pkg::S_IDLE: begin
        w   <= req.rect_width;
        h   <= req.rect_height;
        cx  <= req.corner_x;
        cy  <= req.corner_y;
        y   <= '0;
        idx <= '0;
        px  <= '0;
        py  <= '0;
        if (req.action == ffra_pkg::ACT_REMOVE) begin
          st <= ffra_pkg::ST_NOT_FOUND;
        end else if (full) begin
          st <= ffra_pkg::ST_FULL;
        end else begin
          st <= ffra_pkg::ST_NO_ROOM;
        end
      end
      ffra_pkg::S_ROW: begin
        row_next <= D'(ah);
        x        <= '0;
      end
      ffra_pkg::S_CAND: begin
        idx <= '0;
        if (cand_fail) begin
          y <= row_next;
        end
      end
      ffra_pkg::S_CHK: begin
        if (hit) begin
          x <= e_right;
          if (e_bottom < row_next) begin
            row_next <= e_bottom;
          end
        end else begin
          idx <= IW'(idx_p1);
        end
      end
      ffra_pkg::S_FOUND: begin
        st <= ffra_pkg::ST_PLACED;
        px <= ffra_pkg::CORN_W'(x);
        py <= ffra_pkg::CORN_W'(y);
      end
      ffra_pkg::S_DEL_CHK: begin
        if (match) begin
          st <= ffra_pkg::ST_REMOVED;
        end else begin
          idx <= IW'(idx_p1);
        end
      end
      ffra_pkg::S_SH_WR: idx <= IW'(idx_p1);
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == ffra_pkg::S_DONE && out_free) begin
      res_valid <= 1'b1;
    end else if (rsp.ready) begin
      res_valid <= 1'b0;
    end
  end

  // payload is frozen with the beat; the count may move on under the next request
  always_ff @(posedge clk) begin
    if (state == ffra_pkg::S_DONE && out_free) begin
      res_status <= st;
      res_x      <= px;
      res_y      <= py;
      res_used   <= ffra_pkg::USED_W'(count);
    end
  end

  assign req.ready        = (state == ffra_pkg::S_IDLE);
  assign rsp.valid        = res_valid;
  assign rsp.status       = res_status;
  assign rsp.out_x        = res_x;
  assign rsp.out_y        = res_y;
  assign rsp.entries_used = res_used;

`ifndef SYNTHESIS
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_RECTS)) else $error("entry count above table size");
  a_place_inc: assert property (@(posedge clk) disable iff (rst)
    state == ffra_pkg::S_FOUND |=> count == $past(count) + CW'(1))
    else $error("placement did not grow the table");
  a_shift_rng: assert property (@(posedge clk) disable iff (rst)
    state == ffra_pkg::S_SH_WR |-> idx_p1 < count)
    else $error("shift past the last entry");
  a_place_full: assert property (@(posedge clk) disable iff (rst)
    state == ffra_pkg::S_FOUND |-> !full) else $error("write into full table");
`endif

endmodule

// ----- design/first_fit_rectangle_allocator.sv -----
// First-fit rectangle allocator top level: configuration, table and sequencer.
//
//  channel  dir   payload                                         beat when
//  req      in    action, rect_width, rect_height, corner_x/y     valid & ready
//  rsp      out   status, out_x, out_y, entries_used              valid & ready
//  cfg      in    reg_index, wr_data                              valid & ready
//
// One request at a time. Each table entry tested is read, then checked against
// the memory's registered output; a place scans the entries for each candidate
// tested, plus row and candidate steps, and a remove reads and checks each entry
// scanned, then reads and writes each entry shifted down. Reset is synchronous
// and empties the table at once; the result register lets a new request start
// while a result waits.
module first_fit_rectangle_allocator #(
  parameter int unsigned MAX_RECTS = ffra_pkg::MAX_RECTS_DEF,
  parameter int unsigned MAX_SIDE  = ffra_pkg::MAX_SIDE_DEF
) (
  input logic        clk,
  input logic        rst,
  ffra_req_if.sink   req,
  ffra_rsp_if.source rsp,
  ffra_cfg_if.sink   cfg
);

  localparam int unsigned IW = $clog2(MAX_RECTS);

  logic [ffra_pkg::SIDE_W-1:0] atlas_width, atlas_height;
  logic [ffra_pkg::SIDE_W-1:0] aw, ah;

  logic             rd_en, wr_en;
  logic [IW-1:0]    rd_addr, wr_addr;
  ffra_pkg::entry_t rd_data, wr_data;

  // configuration registers
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      atlas_width  <= ffra_pkg::SIDE_W'(ffra_pkg::ATLAS_RESET);
      atlas_height <= ffra_pkg::SIDE_W'(ffra_pkg::ATLAS_RESET);
    end else if (cfg.valid) begin
      if (cfg.reg_index == ffra_pkg::REG_ATLAS_WIDTH) begin
        atlas_width <= cfg.wr_data;
      end else begin
        atlas_height <= cfg.wr_data;
      end
    end
  end

  // clamp atlas to the largest supported side
  assign aw = (32'(atlas_width) > 32'(MAX_SIDE)) ? ffra_pkg::SIDE_W'(MAX_SIDE) : atlas_width;
  assign ah = (32'(atlas_height) > 32'(MAX_SIDE)) ? ffra_pkg::SIDE_W'(MAX_SIDE) : atlas_height;

  ffra_table #(.MAX_RECTS(MAX_RECTS)) u_table (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  ffra_ctrl #(.MAX_RECTS(MAX_RECTS)) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .aw      (aw),
    .ah      (ah),
    .req     (req),
    .rsp     (rsp),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

endmodule

// ----- dv/ffra_checker.sv -----
// Checker for the rectangle allocator: mirrors the table, predicts each response, compares.
`timescale 1ns / 100ps

module ffra_checker (
  input  logic       clk,
  input  logic       rst,
  ffra_req_if        req,
  ffra_rsp_if        rsp,
  ffra_cfg_if        cfg,
  output int         fail_count,
  output int         pending
);
  import ffra_pkg::*;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned SIDE_LIMIT  = 4096;

  typedef struct packed {
    status_t           status;
    logic [CORN_W-1:0] x;
    logic [CORN_W-1:0] y;
    logic [USED_W-1:0] used;
  } outcome_t;

  // Mirror of the allocator state
  int unsigned atlas_w, atlas_h, used_cnt;
  int unsigned pl_x [TABLE_DEPTH];
  int unsigned pl_y [TABLE_DEPTH];
  int unsigned pl_w [TABLE_DEPTH];
  int unsigned pl_h [TABLE_DEPTH];
  outcome_t    awaited [$];

  assign pending = awaited.size();

  task automatic report(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // First table entry overlapping the candidate, or used_cnt
  function automatic int unsigned overlap_index(int unsigned x, int unsigned y,
                                                int unsigned w, int unsigned h);
    for (int unsigned i = 0; i < used_cnt; i++)
      if (x < pl_x[i] + pl_w[i] && pl_x[i] < x + w &&
          y < pl_y[i] + pl_h[i] && pl_y[i] < y + h)
        return i;
    return used_cnt;
  endfunction

  // First-fit search, rows from the top
  function automatic bit find_spot(int unsigned w, int unsigned h,
                                   output int unsigned fx, output int unsigned fy);
    int unsigned aw, ah, y, x, row_next, k, bot;
    aw = (atlas_w > SIDE_LIMIT) ? SIDE_LIMIT : atlas_w;
    ah = (atlas_h > SIDE_LIMIT) ? SIDE_LIMIT : atlas_h;
    y = 0;
    fx = 0;
    fy = 0;
    while (y + h <= ah) begin
      row_next = ah;
      x = 0;
      while (x + w <= aw) begin
        k = overlap_index(x, y, w, h);
        if (k >= used_cnt) begin
          fx = x;
          fy = y;
          return 1;
        end
        bot = pl_y[k] + pl_h[k];
        if (bot < row_next) row_next = bot;
        x = pl_x[k] + pl_w[k];
      end
      y = row_next;
    end
    return 0;
  endfunction

  function automatic outcome_t apply_request(action_t act, int unsigned w, int unsigned h,
                                             int unsigned cx, int unsigned cy);
    outcome_t o;
    int unsigned fx, fy;
    o = '0;
    if (act == ACT_PLACE) begin
      if (used_cnt >= TABLE_DEPTH) o.status = ST_FULL;
      else if (w == 0 || h == 0 || !find_spot(w, h, fx, fy)) o.status = ST_NO_ROOM;
      else begin
        pl_x[used_cnt] = fx;
        pl_y[used_cnt] = fy;
        pl_w[used_cnt] = w;
        pl_h[used_cnt] = h;
        used_cnt++;
        o.status = ST_PLACED;
        o.x = CORN_W'(fx);
        o.y = CORN_W'(fy);
      end
    end else begin
      o.status = ST_NOT_FOUND;
      for (int unsigned i = 0; i < used_cnt; i++)
        if (pl_x[i] == cx && pl_y[i] == cy) begin
          for (int unsigned j = i; j + 1 < used_cnt; j++) begin
            pl_x[j] = pl_x[j+1];
            pl_y[j] = pl_y[j+1];
            pl_w[j] = pl_w[j+1];
            pl_h[j] = pl_h[j+1];
          end
          used_cnt--;
          o.status = ST_REMOVED;
          break;
        end
    end
    o.used = USED_W'(used_cnt);
    return o;
  endfunction

  // Watch request, config and response beats
  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      atlas_w = 512;
      atlas_h = 512;
      used_cnt = 0;
      awaited.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.reg_index == REG_ATLAS_WIDTH) atlas_w = cfg.wr_data;
        else atlas_h = cfg.wr_data;
      end
      if (rsp.valid && rsp.ready) begin
        if (awaited.size() == 0) report("unexpected beat", rsp.status, -1);
        else begin
          want = awaited.pop_front();
          if (rsp.status !== want.status) report("status", rsp.status, want.status);
          if (rsp.out_x !== want.x) report("out_x", rsp.out_x, want.x);
          if (rsp.out_y !== want.y) report("out_y", rsp.out_y, want.y);
          if (rsp.entries_used !== want.used)
            report("entries_used", rsp.entries_used, want.used);
        end
      end
      if (req.valid && req.ready)
        awaited.insert(awaited.size(),
                       apply_request(action_t'(req.action), req.rect_width,
                                     req.rect_height, req.corner_x, req.corner_y));
    end
  end

  initial fail_count = 0;
endmodule

// ----- dv/first_fit_rectangle_allocator_tb.sv -----
// Testbench top: clock, reset, request and config stimulus, verdict.
`timescale 1ns / 100ps

module first_fit_rectangle_allocator_tb;
  import ffra_pkg::*;

  logic clk = 0;
  logic rst = 1;
  int   fail_count, pending;
  int   send_idle, recv_stall;
  bit   hold_rsp;
  int   cycle_cnt;
  int   placed_x [$];
  int   placed_y [$];

  ffra_req_if req ();
  ffra_rsp_if rsp ();
  ffra_cfg_if cfg ();

  first_fit_rectangle_allocator uut (.clk, .rst, .req, .rsp, .cfg);
  ffra_checker chk (.clk, .rst, .req, .rsp, .cfg, .fail_count, .pending);

  always #6 clk = ~clk;

  // Receiver: random stalls plus an optional long hold-off
  always @(posedge clk) begin
    if (rst) rsp.ready <= 0;
    else rsp.ready <= !hold_rsp && ($urandom_range(99) >= recv_stall);
  end

  // Remember placed corners for remove requests
  always @(posedge clk)
    if (!rst && rsp.valid && rsp.ready && rsp.status == ST_PLACED) begin
      placed_x.insert(placed_x.size(), rsp.out_x);
      placed_y.insert(placed_y.size(), rsp.out_y);
      if (placed_x.size() > 80) begin
        void'(placed_x.pop_front());
        void'(placed_y.pop_front());
      end
    end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > 100000000) begin
      $display("first_fit_rectangle_allocator_tb failed");
      $finish;
    end
  end

  // Valid stays high after a beat; idle gaps and drain take it down
  task automatic send(action_t act, int w, int h, int cx, int cy);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      req.valid <= 0;
      @(posedge clk);
    end
    req.valid       <= 1;
    req.action      <= act;
    req.rect_width  <= SIDE_W'(w);
    req.rect_height <= SIDE_W'(h);
    req.corner_x    <= CORN_W'(cx);
    req.corner_y    <= CORN_W'(cy);
    do @(posedge clk); while (!req.ready);
  endtask

  task automatic wait_empty();
    req.valid <= 0;
    while (pending != 0) @(posedge clk);
  endtask

  task automatic drain();
    wait_empty();
    repeat (50) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, int val);
    cfg.valid     <= 1;
    cfg.reg_index <= idx;
    cfg.wr_data   <= SIDE_W'(val);
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 0;
    @(posedge clk);
  endtask

  // Mostly small shapes, sometimes anything
  task automatic random_item();
    int k, w, h;
    k = $urandom_range(99);
    if (k < 60) begin
      w = $urandom_range(64, 1);
      h = $urandom_range(64, 1);
      if ($urandom_range(9) == 0) w = $urandom_range(8191);
      if ($urandom_range(9) == 0) h = $urandom_range(8191);
      send(ACT_PLACE, w, h, 0, 0);
    end else if (k < 90 && placed_x.size() > 0) begin
      k = $urandom_range(placed_x.size() - 1);
      send(ACT_REMOVE, 0, 0, placed_x[k], placed_y[k]);
    end else
      send(ACT_REMOVE, $urandom_range(8191), $urandom_range(8191),
           $urandom_range(4095), $urandom_range(4095));
  endtask

  initial begin
    req.valid = 0; req.action = 0; req.rect_width = 0; req.rect_height = 0;
    req.corner_x = 0; req.corner_y = 0;
    cfg.valid = 0; cfg.reg_index = 0; cfg.wr_data = 0;
    send_idle = 0; recv_stall = 0; hold_rsp = 0;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: default atlas, extremes, zero size, duplicates, unknown corner
    send(ACT_PLACE, 0, 5, 0, 0);
    send(ACT_PLACE, 5, 0, 0, 0);
    send(ACT_PLACE, 8191, 8191, 4095, 4095);
    send(ACT_PLACE, 513, 1, 0, 0);
    send(ACT_PLACE, 512, 512, 0, 0);
    send(ACT_PLACE, 1, 1, 0, 0);
    send(ACT_REMOVE, 0, 0, 0, 0);
    send(ACT_REMOVE, 0, 0, 0, 0);
    send(ACT_REMOVE, 8191, 8191, 4095, 4095);
    send(ACT_PLACE, 100, 30, 0, 0);
    send(ACT_PLACE, 50, 60, 0, 0);
    send(ACT_PLACE, 400, 10, 0, 0);
    send(ACT_PLACE, 30, 30, 0, 0);
    drain();
    // Zero atlas fits nothing; huge atlas clamps; duplicate corners
    write_reg(REG_ATLAS_WIDTH, 0);
    write_reg(REG_ATLAS_HEIGHT, 8191);
    send(ACT_PLACE, 1, 1, 0, 0);
    drain();
    write_reg(REG_ATLAS_WIDTH, 8191);
    send(ACT_PLACE, 4096, 1, 0, 0);
    send(ACT_PLACE, 4096, 4096, 0, 0);
    drain();
    write_reg(REG_ATLAS_WIDTH, 1);
    write_reg(REG_ATLAS_HEIGHT, 1);
    send(ACT_PLACE, 1, 1, 0, 0);
    send(ACT_REMOVE, 0, 0, 0, 0);
    drain();
    // Fill the table to full with tiny rectangles
    write_reg(REG_ATLAS_WIDTH, 16);
    write_reg(REG_ATLAS_HEIGHT, 16);
    for (int i = 0; i < 66; i++) send(ACT_PLACE, 1, 1, 0, 0);
    for (int i = 0; i < 70; i++) send(ACT_REMOVE, 0, 0, i % 16, i / 16);
    drain();

    // Random phases over several atlas settings and idling patterns
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(REG_ATLAS_WIDTH, 512); write_reg(REG_ATLAS_HEIGHT, 512); end
        1: begin write_reg(REG_ATLAS_WIDTH, 128); write_reg(REG_ATLAS_HEIGHT, 96); end
        2: begin write_reg(REG_ATLAS_WIDTH, 4096); write_reg(REG_ATLAS_HEIGHT, 4096); end
        3: begin write_reg(REG_ATLAS_WIDTH, 200); write_reg(REG_ATLAS_HEIGHT, 300); end
        4: begin write_reg(REG_ATLAS_WIDTH, 64); write_reg(REG_ATLAS_HEIGHT, 64); end
        default: begin
          write_reg(REG_ATLAS_WIDTH, $urandom_range(8191));
          write_reg(REG_ATLAS_HEIGHT, $urandom_range(8191));
        end
      endcase
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 85; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 85; end
        default: begin send_idle = 35; recv_stall = 35; end
      endcase
      for (int i = 0; i < 300; i++) begin
        if (ph == 2 && i == 100) begin
          // Long receiver hold-off while requests keep coming
          fork
            begin
              hold_rsp <= 1;
              repeat (3000) @(posedge clk);
              hold_rsp <= 0;
            end
          join_none
        end
        if (ph == 3 && i == 150) wait_empty();
        random_item();
      end
      drain();
      // Forget the remembered corners; the table itself keeps its entries
      placed_x.delete();
      placed_y.delete();
    end

    drain();
    if (fail_count == 0) $display("first_fit_rectangle_allocator_tb passed");
    else $display("first_fit_rectangle_allocator_tb failed");
    $finish;
  end
endmodule
